[design/sca_pkg.sv]
// Shared types, character codes and helper functions of the servo ASCII command framer.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package sca_pkg;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned CONV_W  = 14;
  localparam int unsigned BCD_W   = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 4;

  localparam logic [VAL_W-1:0] PULSE_MIN = 16'd500;
  localparam logic [VAL_W-1:0] PULSE_MAX = 16'd2500;
  localparam logic [VAL_W-1:0] TIME_MAX  = 16'd9999;
  localparam logic [ID_W-1:0]  ID_REJECT = 8'd255;

  localparam logic ACT_MOVE = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
  localparam logic [BYTE_W-1:0] CH_P    = 8'h50;
  localparam logic [BYTE_W-1:0] CH_T    = 8'h54;
  localparam logic [BYTE_W-1:0] CH_R    = 8'h52;
  localparam logic [BYTE_W-1:0] CH_A    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_D    = 8'h44;
  localparam logic [BYTE_W-1:0] CH_BANG = 8'h21;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;

  // Byte positions within a frame.
  localparam logic [IDX_W-1:0] POS_HASH = 4'd0;
  localparam logic [IDX_W-1:0] POS_ID2  = 4'd1;
  localparam logic [IDX_W-1:0] POS_ID1  = 4'd2;
  localparam logic [IDX_W-1:0] POS_ID0  = 4'd3;
  localparam logic [IDX_W-1:0] POS_P    = 4'd4;
  localparam logic [IDX_W-1:0] POS_5    = 4'd5;
  localparam logic [IDX_W-1:0] POS_6    = 4'd6;
  localparam logic [IDX_W-1:0] POS_7    = 4'd7;
  localparam logic [IDX_W-1:0] POS_8    = 4'd8;
  localparam logic [IDX_W-1:0] POS_T    = 4'd9;
  localparam logic [IDX_W-1:0] POS_10   = 4'd10;
  localparam logic [IDX_W-1:0] POS_11   = 4'd11;
  localparam logic [IDX_W-1:0] POS_12   = 4'd12;
  localparam logic [IDX_W-1:0] POS_13   = 4'd13;
  localparam logic [IDX_W-1:0] POS_14   = 4'd14;
  localparam logic [IDX_W-1:0] POS_READ_LAST = POS_8;
  localparam logic [IDX_W-1:0] POS_MOVE_LAST = POS_14;

  // Two conversion steps per cycle over the 14-bit operands.
  localparam int unsigned CONV_STEPS = CONV_W / 2;
  localparam int unsigned CNT_W      = $clog2(CONV_STEPS + 1);

  typedef struct packed {
    logic             action;
    logic [BCD_W-1:0] id_bcd;
    logic [BCD_W-1:0] pulse_bcd;
    logic [BCD_W-1:0] time_bcd;
  } frame_t;

  // One shift-and-add-three step of a binary to BCD conversion.
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd, input logic b);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < BCD_W / 4; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

  function automatic logic [BYTE_W-1:0] digit_char(input logic [3:0] d);
    return CH_ZERO | {4'b0000, d};
  endfunction

endpackage
`default_nettype wire

[design/sca_cmd_if.sv]
// Command channel of the servo ASCII command framer: valid/ready plus the command fields.
// Depends on sca_pkg for field widths.
`default_nettype none
interface sca_cmd_if;
  import sca_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [ID_W-1:0]  servo_id;
  logic [VAL_W-1:0] pulse_width;
  logic [VAL_W-1:0] move_time;

  modport source (output valid, action, servo_id, pulse_width, move_time, input ready);
  modport sink   (input valid, action, servo_id, pulse_width, move_time, output ready);
endinterface
`default_nettype wire

[design/sca_byte_if.sv]
// Byte channel of the servo ASCII command framer: valid/ready, one frame byte and its end flag.
// Depends on sca_pkg for the byte width.
`default_nettype none
interface sca_byte_if;
  import sca_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface
`default_nettype wire

[design/sca_front.sv]
// Front end: accepts commands, drops rejected ids, clamps and converts the fields to BCD.
// Depends on sca_pkg and sca_cmd_if; hands finished frames to sca_queue.
`default_nettype none
module sca_front (
  input  wire logic           clk,
  input  wire logic           rst,
  sca_cmd_if.sink             cmd,
  output sca_pkg::frame_t     push_frame,
  output logic                push,
  input  wire logic           q_full
);
  import sca_pkg::*;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [CONV_W-1:0] id_sh, pulse_sh, time_sh;
  logic [BCD_W-1:0]  id_bcd, pulse_bcd, time_bcd;
  logic              action;
  logic              done;
  logic              take;
  logic [VAL_W-1:0]  pulse_cl, time_cl;

  assign done      = (cnt == CNT_W'(CONV_STEPS));
  assign push      = busy && done && !q_full;
  assign cmd.ready = !busy || push;
  assign take      = cmd.valid && cmd.ready;

  always_comb begin
    if (cmd.pulse_width < PULSE_MIN) begin
      pulse_cl = PULSE_MIN;
    end else if (cmd.pulse_width > PULSE_MAX) begin
      pulse_cl = PULSE_MAX;
    end else begin
      pulse_cl = cmd.pulse_width;
    end
    time_cl = (cmd.move_time > TIME_MAX) ? TIME_MAX : cmd.move_time;
  end

  assign push_frame = '{action: action, id_bcd: id_bcd, pulse_bcd: pulse_bcd,
                        time_bcd: time_bcd};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (take && cmd.servo_id != ID_REJECT) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (take || push) begin
      busy <= 1'b0;
    end else if (busy && !done) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      action    <= cmd.action;
      id_sh     <= {{(CONV_W-ID_W){1'b0}}, cmd.servo_id};
      pulse_sh  <= pulse_cl[CONV_W-1:0];
      time_sh   <= time_cl[CONV_W-1:0];
      id_bcd    <= '0;
      pulse_bcd <= '0;
      time_bcd  <= '0;
    end else if (busy && !done) begin
      id_bcd    <= dd_step(dd_step(id_bcd, id_sh[CONV_W-1]), id_sh[CONV_W-2]);
      pulse_bcd <= dd_step(dd_step(pulse_bcd, pulse_sh[CONV_W-1]), pulse_sh[CONV_W-2]);
      time_bcd  <= dd_step(dd_step(time_bcd, time_sh[CONV_W-1]), time_sh[CONV_W-2]);
      id_sh     <= {id_sh[CONV_W-3:0], 2'b00};
      pulse_sh  <= {pulse_sh[CONV_W-3:0], 2'b00};
      time_sh   <= {time_sh[CONV_W-3:0], 2'b00};
    end
  end

endmodule
`default_nettype wire

[design/sca_queue.sv]
// Two-entry queue of converted frames between the front end and the byte emitter.
// Depends on sca_pkg for the frame type.
`default_nettype none
module sca_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire sca_pkg::frame_t push_frame,
  output logic                 full,
  input  wire logic            pop,
  output logic                 q_valid,
  output sca_pkg::frame_t      head
);
  import sca_pkg::*;

  frame_t     slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_frame;
    end
  end

endmodule
`default_nettype wire

[design/sca_back.sv]
// Back end: walks a queued frame byte by byte into a registered output stage.
// Depends on sca_pkg and sca_byte_if; takes frames from sca_queue.
`default_nettype none
module sca_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire sca_pkg::frame_t head,
  output logic                 pop,
  sca_byte_if.source           frame
);
  import sca_pkg::*;

  frame_t            cur;
  logic              loaded;
  logic [IDX_W-1:0]  idx;
  logic              ovalid;
  logic [BYTE_W-1:0] obyte;
  logic              oend;
  logic              can_load;
  logic              last;
  logic [BYTE_W-1:0] byte_sel;

  assign can_load = !ovalid || frame.ready;
  assign last     = (cur.action == ACT_READ) ? (idx == POS_READ_LAST) : (idx == POS_MOVE_LAST);
  assign pop      = q_valid && (!loaded || (can_load && last));

  always_comb begin
    byte_sel = CH_BANG;
    unique case (idx)
      POS_HASH: byte_sel = CH_HASH;
      POS_ID2:  byte_sel = digit_char(cur.id_bcd[11:8]);
      POS_ID1:  byte_sel = digit_char(cur.id_bcd[7:4]);
      POS_ID0:  byte_sel = digit_char(cur.id_bcd[3:0]);
      POS_P:    byte_sel = CH_P;
      POS_5:    byte_sel = (cur.action == ACT_READ) ? CH_R : digit_char(cur.pulse_bcd[15:12]);
      POS_6:    byte_sel = (cur.action == ACT_READ) ? CH_A : digit_char(cur.pulse_bcd[11:8]);
      POS_7:    byte_sel = (cur.action == ACT_READ) ? CH_D : digit_char(cur.pulse_bcd[7:4]);
      POS_8:    byte_sel = (cur.action == ACT_READ) ? CH_BANG : digit_char(cur.pulse_bcd[3:0]);
      POS_T:    byte_sel = CH_T;
      POS_10:   byte_sel = digit_char(cur.time_bcd[15:12]);
      POS_11:   byte_sel = digit_char(cur.time_bcd[11:8]);
      POS_12:   byte_sel = digit_char(cur.time_bcd[7:4]);
      POS_13:   byte_sel = digit_char(cur.time_bcd[3:0]);
      default:  byte_sel = CH_BANG;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
      ovalid <= 1'b0;
      idx    <= '0;
    end else begin
      if (loaded && can_load) begin
        ovalid <= 1'b1;
        if (last) begin
          loaded <= q_valid;
          idx    <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end else begin
        if (can_load) begin
          ovalid <= 1'b0;
        end
        if (!loaded && q_valid) begin
          loaded <= 1'b1;
          idx    <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (loaded && can_load) begin
      obyte <= byte_sel;
      oend  <= last;
    end
  end

  assign frame.valid      = ovalid;
  assign frame.frame_byte = obyte;
  assign frame.frame_end  = oend;

endmodule
`default_nettype wire

[design/servo_ascii_command_framer.sv]
// Top level of the servo ASCII command framer: front end, frame queue and byte emitter.
// Depends on sca_pkg, sca_cmd_if, sca_byte_if, sca_front, sca_queue and sca_back.
//
// Usage. Commands arrive on the cmd channel (action, servo_id, pulse_width, move_time)
// and each accepted command transfer, bar those with servo_id 255, becomes an ASCII frame
// on the frame channel, one byte per transfer, with frame_end high on the closing '!'. A
// move command gives 15 bytes, "#iiiPppppTtttt!", with the pulse clamped to 500..2500
// and the time to 9999; a read command gives the 9 bytes "#iiiPRAD!". A servo_id of 255
// is accepted and dropped without any output.
// The front end registers the command and converts the three numbers to decimal two
// bits a cycle; the finished frame is then written into a two-entry queue once it has
// room, loaded from there into the emitter and passed on into the output register,
// which presents the first byte. Throughput is set by the byte emitter, which sends one
// byte per cycle when the receiver never stalls. The front end takes no new command
// while it is still converting the previous one, and keeps converting while earlier
// frames are still being sent.
// Reset (synchronous, active high) empties the queue and the output register and
// abandons any frame in flight. When the receiver holds ready low the output byte is
// held stable; the queue then fills and cmd.ready falls until room appears.
`default_nettype none
module servo_ascii_command_framer (
  input  wire logic clk,
  input  wire logic rst,
  sca_cmd_if.sink   cmd,
  sca_byte_if.source frame
);
  import sca_pkg::*;

  frame_t push_frame;
  frame_t head;
  logic   push;
  logic   q_full;
  logic   q_valid;
  logic   pop;

  // Front end: accept, clamp and convert to BCD.
  sca_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_frame (push_frame),
    .push       (push),
    .q_full     (q_full)
  );

  // Short queue so the converter and the emitter stall independently.
  sca_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head)
  );

  // Back end: one byte per cycle into the registered output while the receiver is ready.
  sca_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .frame   (frame)
  );

endmodule
`default_nettype wire
